// ===== hw/rtl/fswa_pkg.sv =====
// Shared types, constants and helper functions for the FIFO server wait accounting unit.
package fswa_pkg;

  localparam int unsigned QUEUE_SLOTS = 8;
  localparam int unsigned PTR_W       = (QUEUE_SLOTS > 2) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned WIDE_W      = PTR_W + CNT_W + 1;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] arr;
    logic [7:0]  svc;
  } job_t;

  typedef struct packed {
    logic avail;
    logic overflow;
    job_t head;
  } qstat_t;

  typedef struct packed {
    logic        started;
    logic        busy;
    logic [15:0] job_id;
    logic [15:0] wait_ticks;
    logic [31:0] wait_acc;
    logic [15:0] tick_now;
  } srv_res_t;

  function automatic ptr_t next_ptr(ptr_t p);
    ptr_t r;
    if (p == PTR_W'(QUEUE_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] count_of(ptr_t tail, ptr_t head);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(tail) - WIDE_W'(head);
    if (tail < head) begin
      w = w + WIDE_W'(QUEUE_SLOTS);
    end
    return w[CNT_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/fswa_queue.sv =====
// Circular job queue with one slot kept empty and a registered head read.
module fswa_queue import fswa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             arrival_i,
  input  logic [7:0]       service_length_i,
  input  logic [15:0]      tick_i,
  input  logic             pop_i,
  output qstat_t           stat_o,
  output logic [CNT_W-1:0] queue_count_o
);

  job_t        mem [QUEUE_SLOTS];
  job_t        rd_q;
  ptr_t        head_q, head_d, tail_q, tail_d, rd_addr;
  logic [15:0] next_id_q, next_id_d;
  logic        full, push, empty_now;
  job_t        new_job;

  always_comb begin
    full          = (next_ptr(tail_q) == head_q);
    push          = step_i & arrival_i & ~full;
    empty_now     = (head_q == tail_q);
    new_job.id    = next_id_q;
    new_job.arr   = tick_i;
    new_job.svc   = service_length_i;
    tail_d        = push ? next_ptr(tail_q) : tail_q;
    head_d        = pop_i ? next_ptr(head_q) : head_q;
    next_id_d     = push ? next_id_q + 16'd1 : next_id_q;
    rd_addr       = next_ptr(head_d);
    stat_o.avail    = ~empty_now | push;
    stat_o.overflow = step_i & arrival_i & full;
    stat_o.head     = empty_now ? new_job : rd_q;
    queue_count_o = count_of(tail_d, head_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      next_id_q <= '0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      next_id_q <= next_id_d;
    end
  end

  // The oldest job is read ahead into a register; a write to the same slot is forwarded.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[tail_d] <= new_job;
    end
    if (push && (tail_d == rd_addr)) begin
      rd_q <= new_job;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/fswa_server.sv =====
// Server countdown, wait computation, saturating wait total and tick counter.
module fswa_server import fswa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  qstat_t   qstat_i,
  output logic     pop_o,
  output logic [15:0] tick_o,
  output srv_res_t res_o
);

  logic [7:0]  remaining_q, remaining_d;
  logic [15:0] current_q, current_d;
  logic [31:0] sum_q, sum_d;
  logic [15:0] tick_q, tick_d;
  logic [15:0] wait_w;
  logic [32:0] sum_ext;
  logic        busy;

  always_comb begin
    busy        = (remaining_q != 8'd0);
    pop_o       = step_i & ~busy & qstat_i.avail;
    wait_w      = tick_q - qstat_i.head.arr;
    sum_ext     = {1'b0, sum_q} + {17'd0, wait_w};
    remaining_d = remaining_q;
    current_d   = current_q;
    sum_d       = sum_q;
    tick_d      = step_i ? tick_q + 16'd1 : tick_q;
    res_o.started    = 1'b0;
    res_o.busy       = 1'b0;
    res_o.job_id     = '0;
    res_o.wait_ticks = '0;
    if (busy) begin
      remaining_d  = step_i ? remaining_q - 8'd1 : remaining_q;
      res_o.busy   = 1'b1;
      res_o.job_id = current_q;
    end else if (qstat_i.avail) begin
      if (step_i) begin
        remaining_d = qstat_i.head.svc;
        current_d   = qstat_i.head.id;
        sum_d       = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
      end
      res_o.started    = 1'b1;
      res_o.job_id     = qstat_i.head.id;
      res_o.wait_ticks = wait_w;
    end
    res_o.wait_acc   = sum_d;
    res_o.tick_now   = tick_q;
    tick_o           = tick_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      current_q   <= '0;
      sum_q       <= '0;
      tick_q      <= '0;
    end else begin
      remaining_q <= remaining_d;
      current_q   <= current_d;
      sum_q       <= sum_d;
      tick_q      <= tick_d;
    end
  end

endmodule

// ===== hw/rtl/fifo_server_wait_accounting_unit.sv =====
// Top level of the FIFO server wait accounting unit with request and result registers.
//
//   Channel  Direction  Handshake               Payload
//   in       request    in_valid_i/in_stall_o   arrival_i, service_length_i
//   out      result     out_valid_o/out_stall_i started_o .. tick_now_o
//
// One request is one tick and yields one result; a new request is taken every cycle
// unless the result side stalls. An accepted request is held in the input register and
// its result is captured in the result register when the request advances.
// The queue and server state advance when a request moves into the result register.
// Reset clears the pointers, counters and valid flags; the job store is not cleared.
// A stalled result holds the input register, which then stalls the request side.
module fifo_server_wait_accounting_unit import fswa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        arrival_i,
  input  logic [7:0]  service_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        started_o,
  output logic        busy_res_o,
  output logic [15:0] job_id_o,
  output logic [15:0] wait_ticks_o,
  output logic [31:0] wait_acc_o,
  output logic        overflow_o,
  output logic [2:0]  queue_count_o,
  output logic [15:0] tick_now_o
);

  logic             in_vld_q, in_vld_d;
  logic             arr_q;
  logic [7:0]       svc_q;
  logic             out_vld_q, out_vld_d;
  logic             adv, step, pop;
  logic [15:0]      tick;
  qstat_t           qstat;
  srv_res_t         res, res_q;
  logic             ovf_q;
  logic [CNT_W-1:0] cnt, cnt_q;

  always_comb begin
    adv        = ~out_vld_q | ~out_stall_i;
    step       = in_vld_q & adv;
    in_stall_o = in_vld_q & ~adv;
    in_vld_d   = in_stall_o | in_valid_i;
    out_vld_d  = step | (out_vld_q & out_stall_i);
  end

  fswa_queue u_queue (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .arrival_i        (arr_q),
    .service_length_i (svc_q),
    .tick_i           (tick),
    .pop_i            (pop),
    .stat_o           (qstat),
    .queue_count_o    (cnt)
  );

  fswa_server u_server (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .qstat_i (qstat),
    .pop_o   (pop),
    .tick_o  (tick),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      arr_q <= arrival_i;
      svc_q <= service_length_i;
    end
    if (step) begin
      res_q <= res;
      ovf_q <= qstat.overflow;
      cnt_q <= cnt;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign started_o     = res_q.started;
  assign busy_res_o    = res_q.busy;
  assign job_id_o      = res_q.job_id;
  assign wait_ticks_o  = res_q.wait_ticks;
  assign wait_acc_o    = res_q.wait_acc;
  assign overflow_o    = ovf_q;
  assign queue_count_o = cnt_q;
  assign tick_now_o    = res_q.tick_now;

endmodule

// ===== hw/rtl/fswa_checker.sv =====
// Port-level checker for the FIFO server wait accounting unit and its bind.
module fswa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        arrival_i,
  input logic [7:0]  service_length_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        started_o,
  input logic        busy_res_o,
  input logic [15:0] job_id_o,
  input logic [15:0] wait_ticks_o,
  input logic [31:0] wait_acc_o,
  input logic        overflow_o,
  input logic [2:0]  queue_count_o,
  input logic [15:0] tick_now_o
);

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(wait_acc_o) && $stable(tick_now_o)
      && $stable(job_id_o))
    else $error("stalled result changed");

  a_start_busy_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(started_o && busy_res_o))
    else $error("job started while server busy");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !started_o |-> wait_ticks_o == 16'd0 &&
      (busy_res_o || job_id_o == 16'd0))
    else $error("idle result carries wait or job id");

endmodule

bind fifo_server_wait_accounting_unit fswa_checker u_fswa_checker (.*);
